[rtl/sahc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stepper axis homing controller.
// Depends on nothing; every other file of the block imports it.
package sahc_pkg;

    // Angles are in hundredths of a degree.
    localparam logic [15:0] FULL_TURN    = 16'd36000;
    localparam logic [15:0] HALF_TURN    = 16'd18000;
    localparam logic [2:0]  DELAY_RELOAD = 3'd4;
    localparam logic [2:0]  SPEED_MIN    = 3'd1;
    localparam logic [2:0]  SPEED_MAX    = 3'd4;

    // Configuration register defaults.
    localparam logic [13:0] STEP_SIZE_RST      = 14'd180;
    localparam logic [10:0] HYSTERESIS_RST     = 11'd50;
    localparam logic [15:0] HOME_MAX_TRAVEL_RST = 16'd9000;
    localparam logic [2:0]  FULL_SPEED_RST     = 3'd4;
    localparam logic [2:0]  SLOW_SPEED_RST     = 3'd1;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_SET_TARGET = 3'd1,
        OP_SET_SPEED  = 3'd2,
        OP_SET_MODE   = 3'd3,
        OP_HOME       = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT  = 3'd0,
        ST_HOME1 = 3'd1,
        ST_HOME2 = 3'd2,
        ST_HOME3 = 3'd3,
        ST_HOME4 = 3'd4,
        ST_READY = 3'd5,
        ST_ERROR = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_CW   = 2'd1,
        MODE_CCW  = 2'd2,
        MODE_TO   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_STEP_SIZE       = 3'd0,
        CFG_HYSTERESIS      = 3'd1,
        CFG_HOME_MAX_TRAVEL = 3'd2,
        CFG_SWITCH_PRESENT  = 3'd3,
        CFG_INVERT_HOME     = 3'd4,
        CFG_FULL_SPEED      = 3'd5,
        CFG_SLOW_SPEED      = 3'd6
    } cfg_index_t;

    // Input word: a tick or a command.
    typedef struct packed {
        op_t         op;
        logic [15:0] value;
        logic        home_sensor;
    } in_word_t;

    // Result word: the axis state after the item.
    typedef struct packed {
        logic        step_level;
        logic        dir_level;
        logic [15:0] position;
        logic [15:0] target;
        status_t     status;
        mode_t       mode;
    } out_word_t;

endpackage

[rtl/stepper_axis_homing_controller_core.sv]
`timescale 1ns / 1ps
// Top level of the stepper axis homing controller: input register, axis
// state update and result register. Depends on sahc_pkg.

// One word in, one word out. A word accepted on the input is held in an
// input register. Once the output register is free or being read, the axis
// state (position, target, homing stage, mode, speed, delay counter, step and
// direction lines) is updated in a single pass, and the result word is loaded
// into the output register at the same edge. A result is offered from the
// output register until it is taken. The state is updated for one word at a
// time, so a new word can be accepted in every cycle while results are taken.
// Configuration registers are written through the cfg channel, which is
// always ready; write them only while no word is in flight.
module stepper_axis_homing_controller_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sahc_pkg::in_word_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sahc_pkg::out_word_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  sahc_pkg::cfg_index_t  cfg_index,
    input  logic [15:0]           cfg_data
);
    import sahc_pkg::*;

    // Configuration registers.
    logic [13:0] step_size_reg;
    logic [10:0] hysteresis_reg;
    logic [15:0] home_max_travel_reg;
    logic        switch_present_reg;
    logic        invert_home_reg;
    logic [2:0]  full_speed_reg;
    logic [2:0]  slow_speed_reg;

    // Axis state.
    logic [15:0] position_reg, position_next;
    logic [15:0] target_reg, target_next;
    status_t     status_reg, status_next;
    mode_t       mode_reg, mode_next;
    logic [2:0]  speed_reg, speed_next;
    logic [2:0]  delay_reg, delay_next;
    logic        dir_reg, dir_next;
    logic        phase_reg, phase_next;

    // Pipeline.
    logic        s1_valid_reg;
    in_word_t    s1_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg, out_word_next;
    logic        advance;

    // Datapath helpers.
    logic               home_seen;
    logic signed [16:0] diff_raw;
    logic signed [16:0] diff_wrap;
    logic [15:0]        diff_mag;
    logic [16:0]        travel_sum;
    logic [16:0]        pos_up;
    logic [16:0]        pos_down;
    logic [15:0]        step_base;
    logic               move_ok;

    // Handshakes.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg       <= STEP_SIZE_RST;
            hysteresis_reg      <= HYSTERESIS_RST;
            home_max_travel_reg <= HOME_MAX_TRAVEL_RST;
            switch_present_reg  <= 1'b1;
            invert_home_reg     <= 1'b0;
            full_speed_reg      <= FULL_SPEED_RST;
            slow_speed_reg      <= SLOW_SPEED_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STEP_SIZE:       step_size_reg       <= cfg_data[13:0];
                CFG_HYSTERESIS:      hysteresis_reg      <= cfg_data[10:0];
                CFG_HOME_MAX_TRAVEL: home_max_travel_reg <= cfg_data;
                CFG_SWITCH_PRESENT:  switch_present_reg  <= cfg_data[0];
                CFG_INVERT_HOME:     invert_home_reg     <= cfg_data[0];
                CFG_FULL_SPEED:      full_speed_reg      <= cfg_data[2:0];
                CFG_SLOW_SPEED:      slow_speed_reg      <= cfg_data[2:0];
                default:             ;
            endcase
        end
    end

    // Shortest wrapped distance to the target, taken from the state before
    // the word is applied, and the homing timeout sum.
    always_comb
    begin
        home_seen  = !switch_present_reg || (s1_word_reg.home_sensor ^ invert_home_reg);
        diff_raw   = $signed({1'b0, target_reg}) - $signed({1'b0, position_reg});
        if (diff_raw > $signed({1'b0, HALF_TURN}))
        begin
            diff_wrap = diff_raw - $signed({1'b0, FULL_TURN});
        end
        else if (diff_raw < -$signed({1'b0, HALF_TURN}))
        begin
            diff_wrap = diff_raw + $signed({1'b0, FULL_TURN});
        end
        else
        begin
            diff_wrap = diff_raw;
        end
        diff_mag   = diff_wrap[16] ? 16'(-diff_wrap) : diff_wrap[15:0];
        travel_sum = {1'b0, position_reg} + {1'b0, home_max_travel_reg};
    end

    // Next axis state for the word in the input register.
    always_comb
    begin
        position_next = position_reg;
        target_next   = target_reg;
        status_next   = status_reg;
        mode_next     = mode_reg;
        speed_next    = speed_reg;
        delay_next    = delay_reg;
        dir_next      = dir_reg;
        phase_next    = phase_reg;
        move_ok       = 1'b0;
        step_base     = position_reg;
        pos_up        = '0;
        pos_down      = '0;

        unique case (s1_word_reg.op)
            OP_TICK:
            begin
                if (status_reg != ST_ERROR)
                begin
                    // Homing sequence.
                    unique case (status_reg)
                        ST_HOME1:
                        begin
                            if (home_seen)
                            begin
                                status_next = ST_HOME2;
                                speed_next  = slow_speed_reg;
                            end
                            else if (travel_sum < {1'b0, FULL_TURN} && position_reg != '0)
                            begin
                                status_next = ST_ERROR;
                                mode_next   = MODE_STOP;
                            end
                        end
                        ST_HOME2:
                        begin
                            if (home_seen)
                            begin
                                status_next   = ST_HOME3;
                                position_next = '0;
                            end
                            else
                            begin
                                status_next = ST_HOME1;
                            end
                        end
                        ST_HOME3:
                        begin
                            if (!home_seen)
                            begin
                                target_next   = (FULL_TURN - position_reg) >> 1;
                                position_next = '0;
                                mode_next     = MODE_TO;
                                status_next   = ST_HOME4;
                            end
                        end
                        ST_HOME4:
                        begin
                            if (diff_mag < {5'b0, hysteresis_reg})
                            begin
                                mode_next     = MODE_STOP;
                                status_next   = ST_READY;
                                speed_next    = full_speed_reg;
                                position_next = '0;
                                target_next   = '0;
                            end
                        end
                        default: ;
                    endcase

                    // Direction from the mode as it now stands.
                    unique case (mode_next)
                        MODE_CW:
                        begin
                            dir_next = 1'b1;
                            move_ok  = 1'b1;
                        end
                        MODE_CCW:
                        begin
                            dir_next = 1'b0;
                            move_ok  = 1'b1;
                        end
                        MODE_TO:
                        begin
                            move_ok  = diff_mag > {5'b0, hysteresis_reg};
                            dir_next = !diff_wrap[16] && (diff_wrap != '0);
                        end
                        default: ;
                    endcase

                    // Step line under the delay counter; position moves on the
                    // falling edge of the step line.
                    step_base = position_next;
                    pos_up    = {1'b0, step_base} + {3'b0, step_size_reg};
                    pos_down  = {1'b0, step_base} - {3'b0, step_size_reg};
                    if (move_ok)
                    begin
                        if (delay_reg <= speed_next)
                        begin
                            delay_next = DELAY_RELOAD;
                            phase_next = !phase_reg;
                            if (phase_reg)
                            begin
                                if (dir_next)
                                begin
                                    position_next = (pos_up > {1'b0, FULL_TURN})
                                        ? 16'(pos_up - {1'b0, FULL_TURN}) : pos_up[15:0];
                                end
                                else
                                begin
                                    position_next = pos_down[16]
                                        ? 16'(pos_down + {1'b0, FULL_TURN}) : pos_down[15:0];
                                end
                            end
                        end
                        else
                        begin
                            delay_next = delay_reg - 3'd1;
                        end
                    end
                end
            end
            OP_SET_TARGET:
            begin
                target_next = (s1_word_reg.value > FULL_TURN) ? FULL_TURN : s1_word_reg.value;
            end
            OP_SET_SPEED:
            begin
                if (s1_word_reg.value == '0)
                begin
                    speed_next = SPEED_MIN;
                end
                else if (s1_word_reg.value > 16'(SPEED_MAX))
                begin
                    speed_next = SPEED_MAX;
                end
                else
                begin
                    speed_next = s1_word_reg.value[2:0];
                end
            end
            OP_SET_MODE:
            begin
                mode_next = (s1_word_reg.value > 16'(MODE_TO)) ? MODE_TO
                                                               : mode_t'(s1_word_reg.value[1:0]);
            end
            OP_HOME:
            begin
                if (home_seen)
                begin
                    status_next   = ST_READY;
                    position_next = '0;
                end
                else
                begin
                    mode_next   = MODE_CCW;
                    status_next = ST_HOME1;
                end
            end
            default: ;
        endcase
    end

    // Result word from the updated state.
    always_comb
    begin
        out_word_next.step_level = phase_next;
        out_word_next.dir_level  = dir_next;
        out_word_next.position   = position_next;
        out_word_next.target     = target_next;
        out_word_next.status     = status_next;
        out_word_next.mode       = mode_next;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_word_reg <= in_data;
        end
    end

    // Axis state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            target_reg    <= '0;
            status_reg    <= ST_INIT;
            mode_reg      <= MODE_STOP;
            speed_reg     <= FULL_SPEED_RST;
            delay_reg     <= FULL_SPEED_RST;
            dir_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                position_reg  <= position_next;
                target_reg    <= target_next;
                status_reg    <= status_next;
                mode_reg      <= mode_next;
                speed_reg     <= speed_next;
                delay_reg     <= delay_next;
                dir_reg       <= dir_next;
                phase_reg     <= phase_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // Checks on the design's own invariants.
    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= FULL_TURN)
        else $error("axis position beyond a full turn");

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        target_reg <= FULL_TURN)
        else $error("target beyond a full turn");

    a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        delay_reg <= DELAY_RELOAD)
        else $error("delay counter above its reload value");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word did not reach the output register");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for stepper_axis_homing_controller_core: directed
// command and homing tests, back-pressure and random traffic over several
// register settings. Depends on sahc_pkg and the core RTL only.
module testbench;

    import sahc_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 150;
    // The op field is three bits wide; codes above OP_HOME do nothing.
    localparam int OP_CODE_MAX    = 7;
    localparam int TURN           = int'(FULL_TURN);
    localparam int HALF           = int'(HALF_TURN);

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_word_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_word_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_STEP_SIZE;
    logic [15:0] cfg_data  = '0;

    // Register copies as the block holds them.
    logic [13:0] reg_step;
    logic [10:0] reg_hyst;
    logic [15:0] reg_travel;
    logic        reg_present;
    logic        reg_invert;
    logic [2:0]  reg_full;
    logic [2:0]  reg_slow;

    // Axis state as predicted.
    int          ax_pos;
    int          ax_tgt;
    status_t     ax_status;
    mode_t       ax_mode;
    logic [2:0]  ax_speed;
    logic [2:0]  ax_delay;
    logic        ax_dir;
    logic        ax_phase;

    out_word_t   expected_axis [$];
    out_word_t   axis_want;
    int          mismatches = 0;
    int          sent_items = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          holdoff_req = 0;
    int          holdoff_seen = 0;
    int          holdoff_left = 0;
    int unsigned stall_tick = 0;

    stepper_axis_homing_controller_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // Axis predictor
    // ---------------------------------------------------------------

    function automatic void reset_axis_model();
        reg_step    = STEP_SIZE_RST;
        reg_hyst    = HYSTERESIS_RST;
        reg_travel  = HOME_MAX_TRAVEL_RST;
        reg_present = 1'b1;
        reg_invert  = 1'b0;
        reg_full    = FULL_SPEED_RST;
        reg_slow    = SLOW_SPEED_RST;
        ax_pos      = 0;
        ax_tgt      = 0;
        ax_status   = ST_INIT;
        ax_mode     = MODE_STOP;
        ax_speed    = FULL_SPEED_RST;
        ax_delay    = FULL_SPEED_RST;
        ax_dir      = 1'b0;
        ax_phase    = 1'b0;
    endfunction

    function automatic void apply_register(cfg_index_t idx, logic [15:0] data);
        case (idx)
            CFG_STEP_SIZE:       reg_step    = data[13:0];
            CFG_HYSTERESIS:      reg_hyst    = data[10:0];
            CFG_HOME_MAX_TRAVEL: reg_travel  = data;
            CFG_SWITCH_PRESENT:  reg_present = data[0];
            CFG_INVERT_HOME:     reg_invert  = data[0];
            CFG_FULL_SPEED:      reg_full    = data[2:0];
            CFG_SLOW_SPEED:      reg_slow    = data[2:0];
            default: ;
        endcase
    endfunction

    // Without a switch fitted the axis always counts as being at home.
    function automatic bit home_is_seen(logic sensor);
        return !reg_present || (sensor ^ reg_invert);
    endfunction

    // Sensor level that makes home seen or not under the current setting.
    function automatic logic sensor_level(bit seen);
        return seen ^ reg_invert;
    endfunction

    function automatic void axis_tick(logic sensor);
        int delta;
        int distance;
        bit seen;
        bit moving;
        seen   = home_is_seen(sensor);
        moving = 1'b0;
        if (ax_status == ST_ERROR)
            return;
        // Shortest wrapped path, worked out before any homing stage runs.
        delta = ax_tgt - ax_pos;
        if (delta > HALF)
            delta -= TURN;
        else if (delta < -HALF)
            delta += TURN;
        distance = (delta < 0) ? -delta : delta;

        case (ax_status)
            ST_HOME1:
                if (seen) begin
                    ax_status = ST_HOME2;
                    ax_speed  = reg_slow;
                end else if (ax_pos < TURN - int'(reg_travel) && ax_pos > 0) begin
                    ax_status = ST_ERROR;
                    ax_mode   = MODE_STOP;
                end
            ST_HOME2:
                if (seen) begin
                    ax_status = ST_HOME3;
                    ax_pos    = 0;
                end else begin
                    ax_status = ST_HOME1;
                end
            ST_HOME3:
                if (!seen) begin
                    ax_tgt    = (TURN - ax_pos) / 2;
                    ax_pos    = 0;
                    ax_mode   = MODE_TO;
                    ax_status = ST_HOME4;
                end
            ST_HOME4:
                if (distance < int'(reg_hyst)) begin
                    ax_mode   = MODE_STOP;
                    ax_status = ST_READY;
                    ax_speed  = reg_full;
                    ax_pos    = 0;
                    ax_tgt    = 0;
                end
            default: ;
        endcase

        case (ax_mode)
            MODE_CW: begin
                ax_dir = 1'b1;
                moving = 1'b1;
            end
            MODE_CCW: begin
                ax_dir = 1'b0;
                moving = 1'b1;
            end
            MODE_TO: begin
                moving = distance > int'(reg_hyst);
                ax_dir = delta > 0;
            end
            default: ;
        endcase

        if (!moving)
            return;
        // The step line toggles when the delay counter allows; position moves
        // on its falling edge and wraps only beyond a full turn or below zero.
        if (ax_delay <= ax_speed) begin
            ax_delay = DELAY_RELOAD;
            if (!ax_phase) begin
                ax_phase = 1'b1;
            end else begin
                ax_phase = 1'b0;
                if (ax_dir) begin
                    ax_pos += int'(reg_step);
                    if (ax_pos > TURN)
                        ax_pos -= TURN;
                end else begin
                    ax_pos -= int'(reg_step);
                    if (ax_pos < 0)
                        ax_pos += TURN;
                end
            end
        end else begin
            ax_delay = ax_delay - 3'd1;
        end
    endfunction

    function automatic out_word_t advance_axis(in_word_t w);
        out_word_t r;
        case (w.op)
            OP_TICK:
                axis_tick(w.home_sensor);
            OP_SET_TARGET:
                ax_tgt = (w.value > FULL_TURN) ? TURN : int'(w.value);
            OP_SET_SPEED:
                ax_speed = (w.value < SPEED_MIN) ? SPEED_MIN :
                           (w.value > SPEED_MAX) ? SPEED_MAX : w.value[2:0];
            OP_SET_MODE:
                ax_mode = (w.value > MODE_TO) ? MODE_TO : mode_t'(w.value[1:0]);
            OP_HOME:
                if (home_is_seen(w.home_sensor)) begin
                    ax_status = ST_READY;
                    ax_pos    = 0;
                end else begin
                    ax_mode   = MODE_CCW;
                    ax_status = ST_HOME1;
                end
            default: ;
        endcase
        r.step_level = ax_phase;
        r.dir_level  = ax_dir;
        r.position   = 16'(ax_pos);
        r.target     = 16'(ax_tgt);
        r.status     = ax_status;
        r.mode       = ax_mode;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ---------------------------------------------------------------

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Each result word is compared with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_axis.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                mismatches++;
            end else begin
                axis_want = expected_axis.pop_front();
                check_field("step_level", 16'(axis_want.step_level),
                            16'(out_data.step_level));
                check_field("dir_level", 16'(axis_want.dir_level), 16'(out_data.dir_level));
                check_field("position", axis_want.position, out_data.position);
                check_field("target", axis_want.target, out_data.target);
                check_field("status", 16'(axis_want.status), 16'(out_data.status));
                check_field("mode", 16'(axis_want.mode), 16'(out_data.mode));
            end
        end
    end

    // The receiver cycles through four stall patterns, and holds off for a
    // long stretch whenever a test asks for it.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready    <= 1'b0;
            holdoff_seen <= 0;
            holdoff_left <= 0;
            stall_tick   <= 0;
        end else if (holdoff_left != 0) begin
            out_ready    <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_seen != holdoff_req) begin
            out_ready    <= 1'b0;
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
        end else begin
            stall_tick <= stall_tick + 1;
            case (stall_tick[8:7])
                2'd0: out_ready <= 1'b1;
                2'd1: out_ready <= ($urandom_range(0, 3) != 0);
                2'd2: out_ready <= (stall_tick[2:0] != 3'd5);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // A run that stops accepting anything on any channel has hung.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Shared stimulus tasks
    // ---------------------------------------------------------------

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    // Sends one word in bursts of random length with random gaps between.
    task automatic send_word(input op_t code, input logic [15:0] value, input logic sensor);
        in_word_t w;
        int gap;
        w.op          = code;
        w.value       = value;
        w.home_sensor = sensor;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        sent_items++;
        expected_axis.push_back(advance_axis(w));
    endtask

    // Stops sending and waits for every expected result, then a little more.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_axis.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_axis_config(input logic [15:0] step, hyst, travel, present,
                                   invert, full, slow);
        logic [15:0] words [0:6];
        words[CFG_STEP_SIZE]       = step;
        words[CFG_HYSTERESIS]      = hyst;
        words[CFG_HOME_MAX_TRAVEL] = travel;
        words[CFG_SWITCH_PRESENT]  = present;
        words[CFG_INVERT_HOME]     = invert;
        words[CFG_FULL_SPEED]      = full;
        words[CFG_SLOW_SPEED]      = slow;
        for (int i = 0; i <= CFG_SLOW_SPEED; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= words[i];
            do @(posedge clk); while (!cfg_ready);
            apply_register(cfg_index_t'(i), words[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // A well-formed homing run with random lengths in each stage.
    task automatic run_homing_sequence();
        int n;
        send_word(OP_HOME, rand16(), sensor_level($urandom_range(0, 9) == 0));
        n = $urandom_range(0, 8);
        repeat (n) send_word(OP_TICK, rand16(), sensor_level(1'b0));
        if ($urandom_range(0, 5) == 0) begin
            send_word(OP_TICK, rand16(), sensor_level(1'b1));
            send_word(OP_TICK, rand16(), sensor_level(1'b0));
        end
        send_word(OP_TICK, rand16(), sensor_level(1'b1));
        send_word(OP_TICK, rand16(), sensor_level(1'b1));
        n = $urandom_range(0, 10);
        repeat (n) send_word(OP_TICK, rand16(), sensor_level(1'b1));
        send_word(OP_TICK, rand16(), sensor_level(1'b0));
        n = $urandom_range(4, 40);
        repeat (n) send_word(OP_TICK, rand16(), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_motion_sequence();
        int n;
        send_word(OP_SET_TARGET, ($urandom_range(0, 9) == 0) ? rand16() :
                  16'($urandom_range(0, TURN)), 1'($urandom_range(0, 1)));
        send_word(OP_SET_SPEED, ($urandom_range(0, 7) == 0) ? rand16() :
                  16'($urandom_range(0, SPEED_MAX + 1)), 1'($urandom_range(0, 1)));
        send_word(OP_SET_MODE, ($urandom_range(0, 7) == 0) ? rand16() :
                  16'($urandom_range(0, MODE_TO + 1)), 1'($urandom_range(0, 1)));
        n = $urandom_range(1, 20);
        repeat (n) send_word(OP_TICK, rand16(), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_noise(input int count);
        repeat (count)
            send_word(op_t'($urandom_range(0, OP_CODE_MAX)), rand16(),
                      1'($urandom_range(0, 1)));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Commands with clamping, unused codes and a tick that has nowhere to go.
    task automatic test_commands();
        send_word(OP_TICK, 16'h0000, 1'b0);
        send_word(OP_SET_TARGET, 16'hFFFF, 1'b0);
        send_word(OP_SET_TARGET, FULL_TURN, 1'b1);
        send_word(OP_SET_SPEED, 16'h0000, 1'b0);
        send_word(OP_SET_SPEED, 16'hFFFF, 1'b1);
        send_word(OP_SET_MODE, 16'hFFFF, 1'b0);
        send_word(OP_TICK, 16'hFFFF, 1'b1);
        send_word(OP_SET_MODE, 16'(MODE_STOP), 1'b0);
        send_word(op_t'(OP_HOME + 1), 16'hFFFF, 1'b1);
        send_word(op_t'(OP_CODE_MAX), 16'hFFFF, 1'b1);
        send_word(OP_SET_TARGET, 16'h0000, 1'b0);
        settle();
    endtask

    // Immediate home, then the full sequence with a relapse to stage one,
    // the stale path on entry to stage four and the final arrival.
    task automatic test_homing_sequence();
        set_axis_config(9000, 1800, 16'(TURN), 1, 0, 4, 4);
        send_word(OP_HOME, 16'h0000, 1'b1);
        send_word(OP_HOME, 16'h0000, 1'b0);
        send_word(OP_TICK, 16'h0000, 1'b0);
        send_word(OP_TICK, 16'h0000, 1'b1);
        send_word(OP_TICK, 16'h0000, 1'b0);
        send_word(OP_TICK, 16'h0000, 1'b1);
        send_word(OP_TICK, 16'h0000, 1'b1);
        send_word(OP_TICK, 16'h0000, 1'b0);
        repeat (4) send_word(OP_TICK, 16'h0000, 1'b0);
        settle();
    endtask

    // Inverted sensor and zero travel: the search times out into the error
    // status, where ticks do nothing until homing is started again.
    task automatic test_homing_timeout();
        set_axis_config(9000, 1800, 0, 1, 1, 4, 4);
        send_word(OP_HOME, 16'h0000, 1'b1);
        repeat (3) send_word(OP_TICK, 16'h0000, 1'b1);
        send_word(OP_TICK, 16'h0000, 1'b0);
        send_word(OP_SET_MODE, 16'(MODE_CW), 1'b0);
        send_word(OP_TICK, 16'h0000, 1'b1);
        send_word(OP_HOME, 16'h0000, 1'b0);
        settle();
    endtask

    // No switch fitted: homing completes at once; then a wrap below zero.
    task automatic test_no_switch();
        set_axis_config(1, 0, 16'hFFFF, 0, 0, 1, 1);
        send_word(OP_HOME, 16'h0000, 1'b0);
        send_word(OP_SET_MODE, 16'(MODE_CCW), 1'b1);
        repeat (2) send_word(OP_TICK, 16'h0000, 1'b0);
        settle();
    endtask

    // Speed codes outside the command range: zero steps on every fifth tick.
    task automatic test_odd_speed_codes();
        set_axis_config(9000, 1800, 16'(TURN), 1, 0, 7, 0);
        send_word(OP_HOME, 16'h0000, 1'b0);
        repeat (7) send_word(OP_TICK, 16'h0000, 1'b1);
        send_word(OP_TICK, 16'h0000, 1'b0);
        settle();
    endtask

    // The receiver holds off while words keep coming, so the input stalls;
    // afterwards the sender waits for every result.
    task automatic test_backpressure();
        set_axis_config(900, 500, 9000, 1, 0, 4, 1);
        holdoff_req++;
        repeat (3) run_motion_sequence();
        settle();
    endtask

    // Random traffic over several register settings, extremes among them.
    task automatic test_random_traffic();
        int pick;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_axis_config(900, 500, 9000, 1, 0, 4, 1);
                1: set_axis_config(1, 0, 0, 1, 1, 1, 4);
                2: set_axis_config(3000, 1800, 16'(TURN), 1, 0, 7, 0);
                3: set_axis_config(rand16(), rand16(), rand16(), rand16(), rand16(),
                                   rand16(), rand16());
                default: set_axis_config(1200, 700, 18000, 0, 1, 3, 2);
            endcase
            sent_items = 0;
            while (sent_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    run_homing_sequence();
                end else if (pick < 75) begin
                    run_motion_sequence();
                end else if (pick < 90) begin
                    run_noise($urandom_range(1, 6));
                end else begin
                    // Homing started and then abandoned part way.
                    send_word(OP_HOME, rand16(), 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 6))
                        send_word(OP_TICK, rand16(), 1'($urandom_range(0, 1)));
                end
            end
            settle();
        end
    endtask

    initial begin
        reset_axis_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_commands();
        test_homing_sequence();
        test_homing_timeout();
        test_no_switch();
        test_odd_speed_codes();
        test_backpressure();
        test_random_traffic();
        settle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_axis.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
rtl/sahc_pkg.sv
rtl/stepper_axis_homing_controller_core.sv
tb/testbench.sv
